// ===== hw/rtl/quadratic_root_solver_defines.svh =====
// Assertion macros used by the quadratic root solver RTL
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// same-cycle implication, checked on i_clk with reset masked
`define QRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("quadratic root solver: assertion failed");

// next-cycle implication, checked on i_clk with reset masked
`define QRS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("quadratic root solver: assertion failed");

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// Package: widths, result codes and pipeline word types of the quadratic root solver
package qrs_pkg;

    localparam int IN_W      = 32;               // port width of a coefficient
    localparam int COEF_W    = 32;               // bits of each coefficient that count
    localparam int FRAC_BITS = 16;               // fraction bits of the results
    localparam int OUT_W     = 49;               // result width

    localparam int PROD_W = 2 * COEF_W;          // b*b and a*c
    localparam int DSC_W  = 2 * COEF_W + 2;      // signed discriminant
    localparam int ROOT_W = (DSC_W + 2 * FRAC_BITS) / 2;  // root bits, one per cell
    localparam int RAD_W  = 2 * ROOT_W;          // scaled |d|
    localparam int SQR_W  = ROOT_W + 3;          // partial remainder of the root
    localparam int NB_W   = COEF_W + FRAC_BITS + 1;       // -b*2^F or -c*2^F
    localparam int NUM_W  = ((NB_W > ROOT_W + 1) ? NB_W : ROOT_W + 1) + 1;
    localparam int DEN_W  = COEF_W + 2;          // 2a or b, signed
    localparam int DVD_W  = NUM_W + 1;           // dividend 2|n|+|den|, quotient bits
    localparam int DSR_W  = DEN_W;               // divisor 2|den|
    localparam int DRM_W  = DSR_W + 1;           // shifted remainder

    localparam logic [DVD_W-1:0] FIX_MAX     = DVD_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [DVD_W-1:0] FIX_MIN_MAG = DVD_W'(64'd1 << (OUT_W - 1));
    localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(64'd1 << (OUT_W - 1));

    typedef enum logic [1:0] {
        CASE_REAL = 2'd0,
        CASE_CPX  = 2'd1,
        CASE_LIN  = 2'd2,
        CASE_NONE = 2'd3
    } t_case;

    typedef struct packed {
        t_case                    kase;
        logic signed [NB_W-1:0]   nb;
        logic signed [DEN_W-1:0]  den;
    } t_sq_side;

    typedef struct packed {
        logic               vld;
        logic [RAD_W-1:0]   rad;
        logic [SQR_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        t_sq_side           side;
    } t_sq_word;

    typedef struct packed {
        t_case  kase;
        logic   neg1;
        logic   neg2;
    } t_dv_side;

    typedef struct packed {
        logic               vld;
        logic [DVD_W-1:0]   n1;
        logic [DVD_W-1:0]   n2;
        logic [DSR_W-1:0]   rem1;
        logic [DSR_W-1:0]   rem2;
        logic [DSR_W-1:0]   dsor;
        t_dv_side           side;
    } t_dv_word;

endpackage

// ===== hw/rtl/qrs_stream_if.sv =====
// Stream interfaces: coefficient word in, root word out
interface qrs_in_if import qrs_pkg::*;;
    logic              valid;
    logic              ready;
    logic [IN_W-1:0]   coef_a;
    logic [IN_W-1:0]   coef_b;
    logic [IN_W-1:0]   coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if import qrs_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [1:0]               root_case;
    logic signed [OUT_W-1:0]  first_value;
    logic signed [OUT_W-1:0]  second_value;
    logic                     saturated;

    modport source (output valid, root_case, first_value, second_value, saturated,
                    input ready);
    modport sink   (input valid, root_case, first_value, second_value, saturated,
                    output ready);
endinterface

// ===== hw/rtl/quadratic_root_solver.sv =====
// Cells: ROOT_W root cells (49 at the default widths), DVD_W divider cells (52).
// Throughput: one coefficient word per cycle while the pipe is not held; the cell chains advance together.
// The whole pipe holds only while the output word waits and the sink is not ready.
// Reset (synchronous, active low) clears every stage valid bit; payload is not reset.
// No kept state between words, so no clearing pass is needed after reset.
`include "quadratic_root_solver_defines.svh"

module quadratic_root_solver import qrs_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qrs_in_if.sink        i_in,
    qrs_out_if.source     o_out
);
    typedef struct packed {
        logic signed [OUT_W-1:0]  val;
        logic                     sat;
    } t_lane;

    // round to nearest from the biased quotient, sign, and clamp
    function automatic t_lane fix_lane(input logic [DVD_W-1:0] q, input logic neg);
        t_lane             res;
        logic [DVD_W-1:0]  m;
        logic [DVD_W-1:0]  mn;
        m       = q;
        res.sat = 1'b0;
        if (neg) begin
            if (q > FIX_MIN_MAG) begin
                res.sat = 1'b1;
                m       = FIX_MIN_MAG;
            end
            mn      = ~m + 1'b1;
            res.val = mn[OUT_W-1:0];
        end else begin
            if (q > FIX_MAX) begin
                res.sat = 1'b1;
                m       = FIX_MAX;
            end
            res.val = m[OUT_W-1:0];
        end
        return res;
    endfunction

    logic w_en;

    logic                      r_f1_vld;
    logic signed [COEF_W-1:0]  r_a;
    logic signed [COEF_W-1:0]  r_b;
    logic signed [COEF_W-1:0]  r_c;
    logic signed [PROD_W-1:0]  r_bb;
    logic signed [PROD_W-1:0]  r_ac;
    logic signed [COEF_W-1:0]  w_a;
    logic signed [COEF_W-1:0]  w_b;
    logic signed [COEF_W-1:0]  w_c;

    logic signed [DSC_W-1:0]   w_d;
    logic signed [DSC_W-1:0]   w_mag;
    t_sq_word                  n_sq0;
    t_sq_word                  r_sq0;
    logic                      r_sq0_vld;
    t_sq_word                  w_sq [0:ROOT_W];

    logic signed [NUM_W-1:0]   w_s;
    logic signed [NUM_W-1:0]   w_nb;
    logic signed [NUM_W-1:0]   w_n1;
    logic signed [NUM_W-1:0]   w_n2;
    logic signed [NUM_W-1:0]   w_a1;
    logic signed [NUM_W-1:0]   w_a2;
    logic signed [DEN_W-1:0]   w_ad;
    logic [DEN_W-2:0]          w_ud;
    t_dv_word                  n_dv0;
    t_dv_word                  r_dv0;
    logic                      r_dv0_vld;
    t_dv_word                  w_dv [0:DVD_W];

    t_lane                     w_l1;
    t_lane                     w_l2;
    logic                      r_out_vld;
    t_case                     r_out_case;
    logic signed [OUT_W-1:0]   r_out_first;
    logic signed [OUT_W-1:0]   r_out_second;
    logic                      r_out_sat;

    // pipe moves unless the output word is held
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // stage 1: decode coefficients, form b*b and a*c
    assign w_a = i_in.coef_a[COEF_W-1:0];
    assign w_b = i_in.coef_b[COEF_W-1:0];
    assign w_c = i_in.coef_c[COEF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld <= 1'b0;
        end else if (w_en) begin
            r_f1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a  <= w_a;
            r_b  <= w_b;
            r_c  <= w_c;
            r_bb <= w_b * w_b;
            r_ac <= w_a * w_c;
        end
    end

    // stage 2: discriminant, case, scaled radicand, numerator base and denominator
    always_comb begin
        w_d   = DSC_W'(r_bb) - (DSC_W'(r_ac) <<< 2);
        w_mag = w_d[DSC_W-1] ? -w_d : w_d;
        n_sq0      = '0;
        n_sq0.vld  = r_f1_vld;
        n_sq0.rad  = RAD_W'(w_mag[DSC_W-2:0]) << (2 * FRAC_BITS);
        priority if (r_a == '0 && r_b != '0) begin
            n_sq0.side.kase = CASE_LIN;
            n_sq0.side.nb   = -(NB_W'(r_c) <<< FRAC_BITS);
            n_sq0.side.den  = DEN_W'(r_b);
        end else if (r_a == '0) begin
            n_sq0.side.kase = CASE_NONE;
            n_sq0.side.nb   = -(NB_W'(r_b) <<< FRAC_BITS);
            n_sq0.side.den  = DEN_W'(r_b);
        end else begin
            n_sq0.side.kase = w_d[DSC_W-1] ? CASE_CPX : CASE_REAL;
            n_sq0.side.nb   = -(NB_W'(r_b) <<< FRAC_BITS);
            n_sq0.side.den  = DEN_W'(r_a) <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq0_vld <= 1'b0;
        end else if (w_en) begin
            r_sq0_vld <= n_sq0.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq0 <= n_sq0;
        end
    end

    always_comb begin
        w_sq[0]     = r_sq0;
        w_sq[0].vld = r_sq0_vld;
    end

    // square root chain
    for (genvar gi = 0; gi < ROOT_W; gi++) begin : g_sq
        qrs_sqrt_cell u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_sq[gi]),
            .o_word  (w_sq[gi+1])
        );
    end

    // numerators per case, then magnitudes and biased dividends
    always_comb begin
        w_s  = $signed({{(NUM_W-ROOT_W){1'b0}}, w_sq[ROOT_W].root});
        w_nb = NUM_W'(w_sq[ROOT_W].side.nb);
        unique case (w_sq[ROOT_W].side.kase)
            CASE_REAL: begin
                w_n1 = w_nb + w_s;
                w_n2 = w_nb - w_s;
            end
            CASE_CPX: begin
                w_n1 = w_nb;
                w_n2 = w_s;
            end
            default: begin
                w_n1 = w_nb;
                w_n2 = '0;
            end
        endcase
        w_a1 = w_n1[NUM_W-1] ? -w_n1 : w_n1;
        w_a2 = w_n2[NUM_W-1] ? -w_n2 : w_n2;
        w_ad = w_sq[ROOT_W].side.den[DEN_W-1] ? -w_sq[ROOT_W].side.den
                                              : w_sq[ROOT_W].side.den;
        w_ud = w_ad[DEN_W-2:0];
        n_dv0           = '0;
        n_dv0.vld       = w_sq[ROOT_W].vld;
        n_dv0.n1        = DVD_W'({w_a1[NUM_W-2:0], 1'b0}) + DVD_W'(w_ud);
        n_dv0.n2        = DVD_W'({w_a2[NUM_W-2:0], 1'b0}) + DVD_W'(w_ud);
        n_dv0.dsor      = {w_ud, 1'b0};
        n_dv0.side.kase = w_sq[ROOT_W].side.kase;
        n_dv0.side.neg1 = w_n1[NUM_W-1] ^ w_sq[ROOT_W].side.den[DEN_W-1];
        n_dv0.side.neg2 = w_n2[NUM_W-1] ^ w_sq[ROOT_W].side.den[DEN_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0_vld <= 1'b0;
        end else if (w_en) begin
            r_dv0_vld <= n_dv0.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv0 <= n_dv0;
        end
    end

    always_comb begin
        w_dv[0]     = r_dv0;
        w_dv[0].vld = r_dv0_vld;
    end

    // divider chain
    for (genvar gj = 0; gj < DVD_W; gj++) begin : g_dv
        qrs_div_cell u_dv (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_word  (w_dv[gj]),
            .o_word  (w_dv[gj+1])
        );
    end

    // output stage: sign, clamp, no-equation word is all zero
    assign w_l1 = fix_lane(w_dv[DVD_W].n1, w_dv[DVD_W].side.neg1);
    assign w_l2 = fix_lane(w_dv[DVD_W].n2, w_dv[DVD_W].side.neg2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv[DVD_W].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_case <= w_dv[DVD_W].side.kase;
            if (w_dv[DVD_W].side.kase == CASE_NONE) begin
                r_out_first  <= '0;
                r_out_second <= '0;
                r_out_sat    <= 1'b0;
            end else begin
                r_out_first  <= w_l1.val;
                r_out_second <= w_l2.val;
                r_out_sat    <= w_l1.sat | w_l2.sat;
            end
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.root_case    = r_out_case;
    assign o_out.first_value  = r_out_first;
    assign o_out.second_value = r_out_second;
    assign o_out.saturated    = r_out_sat;

    `QRS_ASSERT_IMP(a_none_zero, r_out_vld && r_out_case == CASE_NONE, r_out_first == '0 && r_out_second == '0 && !r_out_sat)
    `QRS_ASSERT_IMP(a_sat_bound, r_out_vld && r_out_sat, r_out_first == OUT_MAX || r_out_first == OUT_MIN || r_out_second == OUT_MAX || r_out_second == OUT_MIN)
    `QRS_ASSERT_NXT(a_stall_hold, !w_en, $stable(w_dv[DVD_W]) && $stable(w_sq[ROOT_W]))
endmodule

// ===== hw/rtl/qrs_sqrt_cell.sv =====
// Square root cell: settles one root bit per stage
module qrs_sqrt_cell import qrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_sq_word  i_word,
    output t_sq_word  o_word
);
    logic              r_vld;
    t_sq_word          r_word;
    t_sq_word          n_word;
    logic [SQR_W-1:0]  w_shift;
    logic [SQR_W-1:0]  w_trial;
    logic              w_ge;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        w_shift = {i_word.rem[SQR_W-3:0], i_word.rad[RAD_W-1 -: 2]};
        w_trial = {{(SQR_W-ROOT_W-2){1'b0}}, i_word.root, 2'b01};
        w_ge    = w_shift >= w_trial;
        n_word      = i_word;
        n_word.rad  = i_word.rad << 2;
        n_word.rem  = w_ge ? (w_shift - w_trial) : w_shift;
        n_word.root = {i_word.root[ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    always_comb begin
        o_word     = r_word;
        o_word.vld = r_vld;
    end
endmodule

// ===== hw/rtl/qrs_div_cell.sv =====
// Divider cell: one quotient bit per stage for both lanes over a shared divisor
module qrs_div_cell import qrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_dv_word  i_word,
    output t_dv_word  o_word
);
    logic              r_vld;
    t_dv_word          r_word;
    t_dv_word          n_word;
    logic [DRM_W-1:0]  w_s1;
    logic [DRM_W-1:0]  w_s2;
    logic [DRM_W-1:0]  w_d;
    logic              w_ge1;
    logic              w_ge2;

    // restoring step: shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_d   = DRM_W'(i_word.dsor);
        w_s1  = {i_word.rem1, i_word.n1[DVD_W-1]};
        w_s2  = {i_word.rem2, i_word.n2[DVD_W-1]};
        w_ge1 = w_s1 >= w_d;
        w_ge2 = w_s2 >= w_d;
        n_word      = i_word;
        n_word.rem1 = w_ge1 ? DSR_W'(w_s1 - w_d) : DSR_W'(w_s1);
        n_word.rem2 = w_ge2 ? DSR_W'(w_s2 - w_d) : DSR_W'(w_s2);
        n_word.n1   = {i_word.n1[DVD_W-2:0], w_ge1};
        n_word.n2   = {i_word.n2[DVD_W-2:0], w_ge2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_word.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    always_comb begin
        o_word     = r_word;
        o_word.vld = r_vld;
    end
endmodule

// ===== tb/quadratic_root_solver_tb.sv =====
// Testbench for the quadratic root solver: queue-fed driver, monitor, in-bench predictor
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    typedef struct {
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] c;
    } t_coefs;

    typedef struct {
        t_case                   kase;
        logic signed [OUT_W-1:0] v1;
        logic signed [OUT_W-1:0] v2;
        logic                    sat;
    } t_roots;

    localparam int NUM_RANDOM  = 1700;
    localparam int STALL_LIMIT = 20000;
    localparam int QUIET_TAIL  = 300;

    logic i_clk;
    logic i_rst_n;

    qrs_in_if  coef_bus ();
    qrs_out_if root_bus ();

    quadratic_root_solver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (coef_bus.sink),
        .o_out   (root_bus.source)
    );

    t_coefs pending_coefs[$];
    t_roots expected_roots[$];
    int     errors = 0;
    int     words_sent = 0;
    bit     feed_done = 0;
    bit     drain_hold = 0;
    bit     calm = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    int     idle_cycles = 0;

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Sign-extend the low COEF_W bits of a port field
    function automatic longint coef_value(logic [IN_W-1:0] raw);
        logic signed [COEF_W-1:0] v;
        v = raw[COEF_W-1:0];
        return longint'(v);
    endfunction

    // Rounded quotient, ties away from zero, clamped to the result range
    function automatic logic signed [OUT_W-1:0] rounded_quotient(
        logic signed [127:0] num, logic signed [127:0] den, inout logic sat);
        logic        neg;
        logic [127:0] un, ud, q;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        if (q == 0)
            return '0;
        if (neg) begin
            if (q > 128'(FIX_MIN_MAG)) begin
                sat = 1'b1;
                q = 128'(FIX_MIN_MAG);
            end
            return OUT_W'(-q);
        end
        if (q > 128'(FIX_MAX)) begin
            sat = 1'b1;
            q = 128'(FIX_MAX);
        end
        return OUT_W'(q);
    endfunction

    // Integer square root, floor, by bitwise trial
    function automatic logic [127:0] floor_sqrt(logic [127:0] x);
        logic [127:0] r, t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (128'd1 << i);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    function automatic t_roots solve_roots(t_coefs w);
        t_roots              r;
        logic signed [127:0] a, b, c, d, nb, s, scale;
        logic [127:0]        mag;
        a = coef_value(w.a);
        b = coef_value(w.b);
        c = coef_value(w.c);
        scale = 128'sd1 <<< FRAC_BITS;
        r.v1 = '0;
        r.v2 = '0;
        r.sat = 1'b0;
        if (a == 0) begin
            if (b != 0) begin
                r.kase = CASE_LIN;
                r.v1 = rounded_quotient(-c * scale, b, r.sat);
            end else begin
                r.kase = CASE_NONE;
            end
        end else begin
            d = b * b - 4 * a * c;
            mag = d < 0 ? -d : d;
            s = floor_sqrt(mag << (2 * FRAC_BITS));
            nb = -b * scale;
            if (d >= 0) begin
                r.kase = CASE_REAL;
                r.v1 = rounded_quotient(nb + s, 2 * a, r.sat);
                r.v2 = rounded_quotient(nb - s, 2 * a, r.sat);
            end else begin
                r.kase = CASE_CPX;
                r.v1 = rounded_quotient(nb, 2 * a, r.sat);
                r.v2 = rounded_quotient(s, 2 * a, r.sat);
            end
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return IN_W'($urandom_range(0, 8)) - IN_W'(4);
            1: return IN_W'($urandom_range(0, 2000)) - IN_W'(1000);
            2: return {1'b1, {(IN_W-1){1'b0}}} + IN_W'($urandom_range(0, 3));
            3: return {1'b0, {(IN_W-1){1'b1}}} - IN_W'($urandom_range(0, 3));
            4: return IN_W'($urandom) >>> $urandom_range(0, 31);
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coef_bus.valid <= 1'b0;
        end else begin
            if (coef_bus.valid && coef_bus.ready) begin
                expected_roots.push_back(solve_roots(pending_coefs.pop_front()));
                words_sent++;
            end
            if (send_gap > 0) begin
                send_gap--;
                coef_bus.valid <= 1'b0;
            end else if (!(coef_bus.valid && !coef_bus.ready)) begin
                if (!calm && $urandom_range(0, 15) == 0) begin
                    send_gap = $urandom_range(1, 11);
                    coef_bus.valid <= 1'b0;
                end else if (pending_coefs.size() > 0 && !drain_hold) begin
                    coef_bus.valid  <= 1'b1;
                    coef_bus.coef_a <= pending_coefs[0].a;
                    coef_bus.coef_b <= pending_coefs[0].b;
                    coef_bus.coef_c <= pending_coefs[0].c;
                end else begin
                    coef_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_roots want;
        if (!i_rst_n) begin
            root_bus.ready <= 1'b0;
        end else begin
            if (root_bus.valid && root_bus.ready) begin
                if (expected_roots.size() == 0) begin
                    $error("unexpected root word");
                    errors++;
                end else begin
                    want = expected_roots.pop_front();
                    if (root_bus.root_case !== want.kase) begin
                        $error("root_case exp %0d got %0d", want.kase, root_bus.root_case);
                        errors++;
                    end
                    if (root_bus.first_value !== want.v1) begin
                        $error("first_value exp %0d got %0d", want.v1, root_bus.first_value);
                        errors++;
                    end
                    if (root_bus.second_value !== want.v2) begin
                        $error("second_value exp %0d got %0d", want.v2,
                               root_bus.second_value);
                        errors++;
                    end
                    if (root_bus.saturated !== want.sat) begin
                        $error("saturated exp %0d got %0d", want.sat, root_bus.saturated);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                root_bus.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                recv_gap = $urandom_range(1, 11);
                root_bus.ready <= 1'b0;
            end else begin
                root_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((coef_bus.valid && coef_bus.ready) || (root_bus.valid && root_bus.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("quadratic_root_solver_tb: FAIL");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        t_coefs       w;
        logic [IN_W-1:0] mx, mn;
        mx = {1'b0, {(IN_W-1){1'b1}}};
        mn = {1'b1, {(IN_W-1){1'b0}}};
        coef_bus.valid = 1'b0;
        coef_bus.coef_a = '0;
        coef_bus.coef_b = '0;
        coef_bus.coef_c = '0;
        root_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no equation, linear, real, double, complex, extremes
        pending_coefs.push_back('{0, 0, 0});
        pending_coefs.push_back('{0, 0, 5});
        pending_coefs.push_back('{0, 3, 7});
        pending_coefs.push_back('{0, -1, mx});
        pending_coefs.push_back('{0, 1, mn});
        pending_coefs.push_back('{0, mn, 1});
        pending_coefs.push_back('{1, -3, 2});
        pending_coefs.push_back('{1, 2, 1});
        pending_coefs.push_back('{1, 0, 1});
        pending_coefs.push_back('{-2, 1, 3});
        pending_coefs.push_back('{1, 1, 1});
        pending_coefs.push_back('{mx, mx, mx});
        pending_coefs.push_back('{mn, mn, mn});
        pending_coefs.push_back('{mx, mn, mx});
        pending_coefs.push_back('{mn, mx, mx});
        pending_coefs.push_back('{1, mn, mn});
        pending_coefs.push_back('{1, mx, mn});
        pending_coefs.push_back('{1, 0, mn});
        pending_coefs.push_back('{-1, 0, mn});
        pending_coefs.push_back('{mx, 1, 0});
        pending_coefs.push_back('{2, 0, 0});
        pending_coefs.push_back('{'1, '1, '1});

        // Random, with one full drain midway
        for (int i = 0; i < NUM_RANDOM; i++) begin
            w.a = ($urandom_range(0, 9) == 0) ? '0 : rand_coef();
            w.b = ($urandom_range(0, 19) == 0) ? '0 : rand_coef();
            w.c = rand_coef();
            pending_coefs.push_back(w);
        end
        wait (pending_coefs.size() <= NUM_RANDOM / 2);
        drain_hold = 1;
        @(posedge i_clk);
        wait (!coef_bus.valid && expected_roots.size() == 0);
        drain_hold = 0;
        wait (pending_coefs.size() < 200);
        calm = 1;
        wait (pending_coefs.size() == 0);
        wait (expected_roots.size() == 0);
        repeat (QUIET_TAIL) @(posedge i_clk);
        if (errors == 0 && expected_roots.size() == 0)
            $display("quadratic_root_solver_tb: PASS");
        else
            $display("quadratic_root_solver_tb: FAIL");
        $finish;
    end
endmodule
